// ===== sv/file_directory_allocator_assert.svh =====
// Assertion macros for the file directory allocator checker.
// Included by the checker file only.
`ifndef FILE_DIRECTORY_ALLOCATOR_ASSERT_SVH
`define FILE_DIRECTORY_ALLOCATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define FDA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FDA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/fda_pkg.sv =====
// Shared types and codes for the file directory allocator.
// No dependencies.
package fda_pkg;

  localparam logic [2:0] OP_FIND   = 3'd0;
  localparam logic [2:0] OP_ALLOC  = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_WRITE  = 3'd4;
  localparam logic [2:0] OP_QUERY  = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ARG      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_EXISTS   = 3'd3;
  localparam logic [2:0] ST_DIRFULL  = 3'd4;
  localparam logic [2:0] ST_DATAFULL = 3'd5;
  localparam logic [2:0] ST_RANGE    = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FIX,
    S_DONE
  } state_t;

endpackage

// ===== sv/file_directory_allocator.sv =====
// File directory allocator: top level with the slot table and its sequencer.
// Depends on fda_pkg.
//
// Usage: one request transaction enters on the in_ channel when in_valid is
// high and in_stall is low. The block then drops readiness (in_stall high)
// while a small sequencer walks the directory one slot per cycle through a
// single key compare unit, recording the first matching slot and the first
// free slot. A delete that finds its key then walks the slots again, one
// per cycle, lowering the offsets of extents that lay above the removed one.
// out_valid rises once the scan and the decide state are through for find,
// allocate, access, query and a delete that misses, and once the fix-up
// sweep is also through for a delete that finds its key. A new request is
// taken only after the result has been taken and the block is back in idle,
// so requests do not overlap.
// The result is held in an output register with out_valid high until the
// receiver takes it; while out_stall is high the block holds the result
// and takes no new request.
// Reset empties the directory, zeroes the fill level and change counter.
module file_directory_allocator #(
  parameter int SLOT_COUNT     = 16,
  parameter int STORE_CAPACITY = 32768,
  parameter int BLOCK_BYTES    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_company_code,
  input  logic [31:0] in_game_code,
  input  logic [63:0] in_name_high,
  input  logic [63:0] in_name_low,
  input  logic [31:0] in_ext_name,
  input  logic [15:0] in_request_size,
  input  logic [5:0]  in_slot,
  input  logic [15:0] in_file_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot_index,
  output logic [15:0] out_payload_address,
  output logic [15:0] out_extent_size,
  output logic [15:0] out_move_source,
  output logic [15:0] out_move_length,
  output logic [63:0] out_change_count,
  output logic [15:0] out_free_bytes,
  output logic [6:0]  out_used_files
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [16:0] CAP = 17'(STORE_CAPACITY);
  localparam logic [16:0] BLK = 17'(BLOCK_BYTES);

  logic [SLOT_COUNT-1:0] used_r;
  logic [15:0] comp_m [SLOT_COUNT];
  logic [31:0] game_m [SLOT_COUNT];
  logic [63:0] nh_m   [SLOT_COUNT];
  logic [63:0] nl_m   [SLOT_COUNT];
  logic [31:0] ext_m  [SLOT_COUNT];
  logic [15:0] off_m  [SLOT_COUNT];
  logic [15:0] size_m [SLOT_COUNT];

  logic [16:0] fill_r;
  logic [63:0] chg_r;
  logic [CW-1:0] nused_r;

  fda_pkg::state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          match_v_r, match_v_nxt;
  logic [IW-1:0] match_r, match_nxt;
  logic          free_v_r, free_v_nxt;
  logic [IW-1:0] free_r, free_nxt;

  // Request registers
  logic [2:0]  op_r;
  logic [15:0] comp_r;
  logic [31:0] game_r;
  logic [63:0] nh_r, nl_r;
  logic [31:0] ext_r;
  logic [15:0] req_r, foff_r;
  logic [5:0]  slot_r;
  logic [16:0] round_r;
  // Delete parameters
  logic [15:0] del_off_r, del_size_r;

  logic        ov_r;
  logic [2:0]  st_r;
  logic [5:0]  si_r;
  logic [15:0] pa_r, es_r, ms_r, ml_r;

  logic accept, done_go;
  assign in_stall = (state_r != fda_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Shared key compare on the slot under the scan pointer.
  logic key_hit;
  assign key_hit = used_r[idx_r] && comp_m[idx_r] == comp_r && game_m[idx_r] == game_r &&
                   nh_m[idx_r] == nh_r && nl_m[idx_r] == nl_r && ext_m[idx_r] == ext_r;

  logic last;
  assign last = (idx_r == IW'(SLOT_COUNT - 1));

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    match_v_nxt = match_v_r;
    match_nxt   = match_r;
    free_v_nxt  = free_v_r;
    free_nxt    = free_r;
    done_go     = 1'b0;
    unique case (state_r)
      fda_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt   = fda_pkg::S_SCAN;
          idx_nxt     = '0;
          match_v_nxt = 1'b0;
          free_v_nxt  = 1'b0;
        end
      end
      fda_pkg::S_SCAN: begin
        if (key_hit && !match_v_r) begin
          match_v_nxt = 1'b1;
          match_nxt   = idx_r;
        end
        if (!used_r[idx_r] && !free_v_r) begin
          free_v_nxt = 1'b1;
          free_nxt   = idx_r;
        end
        if (last) state_nxt = fda_pkg::S_DECIDE;
        else idx_nxt = idx_r + 1'b1;
      end
      fda_pkg::S_DECIDE: begin
        idx_nxt = '0;
        if (op_r == fda_pkg::OP_DELETE && match_v_r) state_nxt = fda_pkg::S_FIX;
        else begin
          state_nxt = fda_pkg::S_DONE;
          done_go   = 1'b1;
        end
      end
      fda_pkg::S_FIX: begin
        if (last) state_nxt = fda_pkg::S_DONE;
        else idx_nxt = idx_r + 1'b1;
      end
      fda_pkg::S_DONE: begin
        if (!ov_r) state_nxt = fda_pkg::S_IDLE;
      end
      default: state_nxt = fda_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fda_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    idx_r     <= idx_nxt;
    match_v_r <= match_v_nxt;
    match_r   <= match_nxt;
    free_v_r  <= free_v_nxt;
    free_r    <= free_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_operation;
      comp_r  <= in_company_code;
      game_r  <= in_game_code;
      nh_r    <= in_name_high;
      nl_r    <= in_name_low;
      ext_r   <= in_ext_name;
      req_r   <= in_request_size;
      foff_r  <= in_file_offset;
      slot_r  <= in_slot;
      round_r <= ((17'(in_request_size) + BLK - 17'd1) / BLK) * BLK;
    end
  end

  // Decision logic, evaluated in S_DECIDE.
  logic [16:0] avail;
  assign avail = (fill_r > CAP) ? 17'd0 : CAP - fill_r;

  logic          slot_ok;
  logic [IW-1:0] sidx;
  assign slot_ok = (32'(slot_r) < 32'(SLOT_COUNT));
  assign sidx    = IW'(slot_r);

  logic [2:0]  d_st;
  logic [5:0]  d_si;
  logic [15:0] d_pa, d_es, d_ms, d_ml;
  logic        d_alloc, d_del, d_chg;
  logic [16:0] del_end;
  logic [16:0] acc_end;

  always_comb begin
    d_st = fda_pkg::ST_OK; d_si = '0; d_pa = '0; d_es = '0; d_ms = '0; d_ml = '0;
    d_alloc = 1'b0; d_del = 1'b0; d_chg = 1'b0;
    del_end = 17'(off_m[match_r]) + 17'(size_m[match_r]);
    acc_end = 17'(foff_r) + 17'(req_r);
    unique case (op_r) inside
      fda_pkg::OP_FIND: begin
        if (!match_v_r) d_st = fda_pkg::ST_NOTFOUND;
        else d_si = 6'(match_r);
      end
      fda_pkg::OP_ALLOC: begin
        if (req_r == '0) d_st = fda_pkg::ST_ARG;
        else if (match_v_r) d_st = fda_pkg::ST_EXISTS;
        else if (!free_v_r) d_st = fda_pkg::ST_DIRFULL;
        else if (round_r > avail) d_st = fda_pkg::ST_DATAFULL;
        else begin
          d_alloc = 1'b1;
          d_chg   = 1'b1;
          d_si    = 6'(free_r);
          d_pa    = fill_r[15:0];
          d_es    = round_r[15:0];
        end
      end
      fda_pkg::OP_DELETE: begin
        if (!match_v_r) d_st = fda_pkg::ST_NOTFOUND;
        else begin
          d_del = 1'b1;
          d_chg = 1'b1;
          d_si  = 6'(match_r);
          d_pa  = off_m[match_r];
          d_es  = size_m[match_r];
          d_ms  = del_end[15:0];
          d_ml  = (fill_r > del_end) ? 16'(fill_r - del_end) : 16'd0;
        end
      end
      fda_pkg::OP_READ, fda_pkg::OP_WRITE, fda_pkg::OP_QUERY: begin
        if (!slot_ok) d_st = fda_pkg::ST_ARG;
        else if (!used_r[sidx]) d_st = fda_pkg::ST_NOTFOUND;
        else if (op_r == fda_pkg::OP_QUERY) begin
          d_si = slot_r;
          d_pa = off_m[sidx];
          d_es = size_m[sidx];
        end else if (acc_end > 17'(size_m[sidx])) d_st = fda_pkg::ST_RANGE;
        else begin
          d_si  = slot_r;
          d_pa  = off_m[sidx] + foff_r;
          d_es  = req_r;
          d_chg = (op_r == fda_pkg::OP_WRITE);
        end
      end
      default: d_st = fda_pkg::ST_ARG;
    endcase
  end

  logic decide;
  assign decide = (state_r == fda_pkg::S_DECIDE);

  // Directory storage and the offset fix-up sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      fill_r  <= '0;
      chg_r   <= '0;
      nused_r <= '0;
      for (int k = 0; k < SLOT_COUNT; k++) begin
        comp_m[k] <= '0; game_m[k] <= '0; nh_m[k] <= '0; nl_m[k] <= '0;
        ext_m[k]  <= '0; off_m[k]  <= '0; size_m[k] <= '0;
      end
    end else begin
      if (decide) begin
        if (d_chg) chg_r <= chg_r + 64'd1;
        if (d_alloc) begin
          used_r[free_r] <= 1'b1;
          comp_m[free_r] <= comp_r; game_m[free_r] <= game_r;
          nh_m[free_r]   <= nh_r;   nl_m[free_r]   <= nl_r;
          ext_m[free_r]  <= ext_r;
          off_m[free_r]  <= fill_r[15:0];
          size_m[free_r] <= round_r[15:0];
          fill_r  <= fill_r + round_r;
          nused_r <= nused_r + 1'b1;
        end
        if (d_del) begin
          del_off_r  <= off_m[match_r];
          del_size_r <= size_m[match_r];
          used_r[match_r] <= 1'b0;
          comp_m[match_r] <= '0; game_m[match_r] <= '0;
          nh_m[match_r]   <= '0; nl_m[match_r]   <= '0;
          ext_m[match_r]  <= '0; off_m[match_r]  <= '0; size_m[match_r] <= '0;
          fill_r  <= (fill_r > 17'(size_m[match_r])) ? fill_r - 17'(size_m[match_r]) : '0;
          nused_r <= nused_r - 1'b1;
        end
      end
      if (state_r == fda_pkg::S_FIX && used_r[idx_r] && off_m[idx_r] > del_off_r) begin
        off_m[idx_r] <= (off_m[idx_r] > del_size_r) ? off_m[idx_r] - del_size_r : '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (done_go || (state_r == fda_pkg::S_FIX && last)) begin
      ov_r <= 1'b1;
    end else if (ov_r && !out_stall) begin
      ov_r <= 1'b0;
    end
    if (decide) begin
      st_r <= d_st; si_r <= d_si; pa_r <= d_pa; es_r <= d_es; ms_r <= d_ms; ml_r <= d_ml;
    end
  end

  logic [16:0] free_now;
  assign free_now = (fill_r > CAP) ? 17'd0 : CAP - fill_r;

  assign out_valid           = ov_r;
  assign out_status          = st_r;
  assign out_slot_index      = si_r;
  assign out_payload_address = pa_r;
  assign out_extent_size     = es_r;
  assign out_move_source     = ms_r;
  assign out_move_length     = ml_r;
  assign out_change_count    = chg_r;
  assign out_free_bytes      = free_now[15:0];
  assign out_used_files      = 7'(nused_r);

endmodule

// ===== sv/fda_checker.sv =====
// Port-level checker for the file directory allocator, bound to the top level.
// Depends on file_directory_allocator_assert.svh and fda_pkg.
`include "file_directory_allocator_assert.svh"
module fda_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [5:0]  out_slot_index,
  input logic [63:0] out_change_count,
  input logic [6:0]  out_used_files
);
  // A request transaction makes the block busy.
  `FDA_ASSERT_NXT(a_busy, in_valid && !in_stall, in_stall)
  // No new request is taken while a result is waiting.
  `FDA_ASSERT_IMP(a_no_overlap, out_valid, in_stall)
  // Failed operations report slot zero.
  `FDA_ASSERT_IMP(a_slot_zero, out_valid && out_status != fda_pkg::ST_OK, out_slot_index == 6'd0)
  // A stalled result holds.
  `FDA_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_change_count) && $stable(out_used_files))
endmodule

bind file_directory_allocator fda_checker u_fda_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_slot_index(out_slot_index), .out_change_count(out_change_count),
  .out_used_files(out_used_files)
);

// ===== verif/tb_top.sv =====
// Testbench for file_directory_allocator: directed and random directory transactions.
// A scoreboard class predicts each result from its own copy of the directory.
// Depends on fda_pkg and the file_directory_allocator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = 16;
  localparam int CAPACITY  = 32768;
  localparam int BLOCK     = 256;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;
  localparam int KEY_POOL  = 24;

  typedef struct packed {
    logic [15:0] company;
    logic [31:0] game;
    logic [63:0] name_high;
    logic [63:0] name_low;
    logic [31:0] ext;
  } file_key_t;

  typedef struct {
    logic [2:0]  operation;
    file_key_t   key;
    logic [15:0] request_size;
    logic [5:0]  slot;
    logic [15:0] file_offset;
  } dir_request_t;

  typedef struct {
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic [15:0] payload_address;
    logic [15:0] extent_size;
    logic [15:0] move_source;
    logic [15:0] move_length;
    logic [63:0] change_count;
    logic [15:0] free_bytes;
    logic [6:0]  used_files;
  } dir_result_t;

  class dir_scoreboard;
    bit          used[NUM_SLOTS];
    file_key_t   keys[NUM_SLOTS];
    int unsigned offsets[NUM_SLOTS];
    int unsigned sizes[NUM_SLOTS];
    int unsigned fill;
    logic [63:0] changes;
    dir_result_t pending[$];
    int          mismatches;
    int          checked;
    int          status_seen[8];

    function int find_key(file_key_t k);
      for (int i = 0; i < NUM_SLOTS; i++)
        if (used[i] && keys[i] == k) return i;
      return -1;
    endfunction

    function void note_request(dir_request_t r);
      dir_result_t e;
      int          hit;
      int          free_slot;
      int unsigned rounded;
      int unsigned avail;
      int unsigned o;
      int unsigned s;
      int unsigned req;
      int unsigned foff;
      int          n;
      e = '{default: '0};
      e.status = fda_pkg::ST_OK;
      req = r.request_size;
      foff = r.file_offset;
      hit = find_key(r.key);
      case (r.operation) inside
        fda_pkg::OP_FIND: begin
          if (hit < 0) e.status = fda_pkg::ST_NOTFOUND;
          else e.slot_index = 6'(hit);
        end
        fda_pkg::OP_ALLOC: begin
          rounded = ((req + BLOCK - 1) / BLOCK) * BLOCK;
          avail = (fill > CAPACITY) ? 0 : CAPACITY - fill;
          free_slot = -1;
          for (int i = 0; i < NUM_SLOTS; i++)
            if (!used[i] && free_slot < 0) free_slot = i;
          if (req == 0) e.status = fda_pkg::ST_ARG;
          else if (hit >= 0) e.status = fda_pkg::ST_EXISTS;
          else if (free_slot < 0) e.status = fda_pkg::ST_DIRFULL;
          else if (rounded > avail) e.status = fda_pkg::ST_DATAFULL;
          else begin
            used[free_slot] = 1'b1;
            keys[free_slot] = r.key;
            offsets[free_slot] = fill;
            sizes[free_slot] = rounded;
            e.slot_index = 6'(free_slot);
            e.payload_address = 16'(fill);
            e.extent_size = 16'(rounded);
            fill += rounded;
            changes++;
          end
        end
        fda_pkg::OP_DELETE: begin
          if (hit < 0) e.status = fda_pkg::ST_NOTFOUND;
          else begin
            o = offsets[hit];
            s = sizes[hit];
            e.slot_index = 6'(hit);
            e.payload_address = 16'(o);
            e.extent_size = 16'(s);
            e.move_source = 16'(o + s);
            e.move_length = 16'((fill > o + s) ? fill - (o + s) : 0);
            fill = (fill > s) ? fill - s : 0;
            used[hit] = 1'b0;
            keys[hit] = '0;
            offsets[hit] = 0;
            sizes[hit] = 0;
            // Every extent above the hole slides down by the removed size.
            for (int k = 0; k < NUM_SLOTS; k++)
              if (used[k] && offsets[k] > o)
                offsets[k] = (offsets[k] > s) ? offsets[k] - s : 0;
            changes++;
          end
        end
        fda_pkg::OP_READ, fda_pkg::OP_WRITE, fda_pkg::OP_QUERY: begin
          if (r.slot >= NUM_SLOTS) e.status = fda_pkg::ST_ARG;
          else if (!used[r.slot]) e.status = fda_pkg::ST_NOTFOUND;
          else if (r.operation == fda_pkg::OP_QUERY) begin
            e.slot_index = r.slot;
            e.payload_address = 16'(offsets[r.slot]);
            e.extent_size = 16'(sizes[r.slot]);
          end else if (foff > sizes[r.slot] || req > sizes[r.slot] - foff) begin
            e.status = fda_pkg::ST_RANGE;
          end else begin
            e.slot_index = r.slot;
            e.payload_address = 16'(offsets[r.slot] + foff);
            e.extent_size = r.request_size;
            if (r.operation == fda_pkg::OP_WRITE) changes++;
          end
        end
        default: e.status = fda_pkg::ST_ARG;
      endcase
      n = 0;
      for (int i = 0; i < NUM_SLOTS; i++) n += used[i];
      e.change_count = changes;
      e.free_bytes = 16'((fill > CAPACITY) ? 0 : CAPACITY - fill);
      e.used_files = 7'(n);
      pending.push_back(e);
    endfunction

    function void flag(string field, logic [63:0] exp_v, logic [63:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %s: expected %0h, got %0h",
                 checked, field, exp_v, act_v);
    endfunction

    function void check_result(dir_result_t a);
      dir_result_t e;
      if (pending.size() == 0) begin
        flag("unexpected transaction", 0, a.status);
        return;
      end
      e = pending.pop_front();
      status_seen[e.status]++;
      if (a.status !== e.status) flag("status", e.status, a.status);
      if (a.slot_index !== e.slot_index) flag("slot_index", e.slot_index, a.slot_index);
      if (a.payload_address !== e.payload_address)
        flag("payload_address", e.payload_address, a.payload_address);
      if (a.extent_size !== e.extent_size) flag("extent_size", e.extent_size, a.extent_size);
      if (a.move_source !== e.move_source) flag("move_source", e.move_source, a.move_source);
      if (a.move_length !== e.move_length) flag("move_length", e.move_length, a.move_length);
      if (a.change_count !== e.change_count)
        flag("change_count", e.change_count, a.change_count);
      if (a.free_bytes !== e.free_bytes) flag("free_bytes", e.free_bytes, a.free_bytes);
      if (a.used_files !== e.used_files) flag("used_files", e.used_files, a.used_files);
      checked++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_operation = '0;
  logic [15:0] in_company_code = '0;
  logic [31:0] in_game_code = '0;
  logic [63:0] in_name_high = '0;
  logic [63:0] in_name_low = '0;
  logic [31:0] in_ext_name = '0;
  logic [15:0] in_request_size = '0;
  logic [5:0]  in_slot = '0;
  logic [15:0] in_file_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [5:0]  out_slot_index;
  logic [15:0] out_payload_address;
  logic [15:0] out_extent_size;
  logic [15:0] out_move_source;
  logic [15:0] out_move_length;
  logic [63:0] out_change_count;
  logic [15:0] out_free_bytes;
  logic [6:0]  out_used_files;

  dir_scoreboard sb = new();
  file_key_t     key_pool[KEY_POOL];
  bit            no_idle = 1'b0;
  int            sent = 0;

  always #1 clk = ~clk;

  file_directory_allocator u_dut (.*);

  // Both channels are observed on the same edge that moves the transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_request('{in_operation,
                          '{in_company_code, in_game_code, in_name_high, in_name_low,
                            in_ext_name},
                          in_request_size, in_slot, in_file_offset});
      if (out_valid && !out_stall)
        sb.check_result('{out_status, out_slot_index, out_payload_address,
                          out_extent_size, out_move_source, out_move_length,
                          out_change_count, out_free_bytes, out_used_files});
    end
  end

  always @(posedge clk)
    out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 38);

  task automatic send(logic [2:0] op, file_key_t k, logic [15:0] req,
                      logic [5:0] slot, logic [15:0] foff);
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_company_code <= k.company;
    in_game_code    <= k.game;
    in_name_high    <= k.name_high;
    in_name_low     <= k.name_low;
    in_ext_name     <= k.ext;
    in_request_size <= req;
    in_slot         <= slot;
    in_file_offset  <= foff;
    do @(posedge clk); while (in_stall);
    sent++;
    if (!no_idle && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  function automatic file_key_t random_key();
    logic [223:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[207:0];
  endfunction

  task automatic random_item();
    file_key_t   k;
    logic [2:0]  op;
    logic [15:0] req;
    logic [15:0] foff;
    logic [5:0]  slot;
    int          pick;
    k = ($urandom_range(0, 9) == 0) ? random_key() : key_pool[$urandom_range(0, KEY_POOL - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 15) op = fda_pkg::OP_FIND;
    else if (pick < 45) op = fda_pkg::OP_ALLOC;
    else if (pick < 60) op = fda_pkg::OP_DELETE;
    else if (pick < 72) op = fda_pkg::OP_READ;
    else if (pick < 84) op = fda_pkg::OP_WRITE;
    else if (pick < 96) op = fda_pkg::OP_QUERY;
    else op = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
    pick = $urandom_range(0, 99);
    if (op == fda_pkg::OP_ALLOC)
      req = 16'((pick < 80) ? $urandom_range(1, 1024) :
                (pick < 95) ? $urandom_range(1, 4096) : $urandom_range(0, 65535));
    else
      req = 16'((pick < 85) ? $urandom_range(0, 600) : $urandom_range(0, 65535));
    foff = 16'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 600)
                                             : $urandom_range(0, 65535));
    slot = 6'(($urandom_range(0, 99) < 85) ? $urandom_range(0, NUM_SLOTS - 1)
                                            : $urandom_range(0, 63));
    send(op, k, req, slot, foff);
  endtask

  initial begin
    file_key_t zero_key;
    file_key_t ones_key;
    zero_key = '0;
    ones_key = '1;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = random_key();
    key_pool[0] = ones_key;
    key_pool[1] = zero_key;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: empty directory, ordering of allocate checks, range edges.
    send(fda_pkg::OP_FIND, ones_key, 16'd0, 6'd0, 16'd0);
    send(fda_pkg::OP_QUERY, ones_key, 16'd0, 6'd0, 16'd0);
    send(fda_pkg::OP_ALLOC, ones_key, 16'd0, 6'd0, 16'd0);
    send(fda_pkg::OP_ALLOC, ones_key, 16'd1, 6'd0, 16'd0);
    send(fda_pkg::OP_ALLOC, ones_key, 16'd0, 6'd0, 16'd0);
    send(fda_pkg::OP_ALLOC, ones_key, 16'd300, 6'd0, 16'd0);
    send(fda_pkg::OP_ALLOC, zero_key, 16'd65535, 6'd0, 16'd0);
    send(fda_pkg::OP_ALLOC, zero_key, 16'd257, 6'd0, 16'd0);
    send(fda_pkg::OP_FIND, zero_key, 16'd0, 6'd0, 16'd0);
    send(fda_pkg::OP_READ, ones_key, 16'd0, 6'd0, 16'd256);
    send(fda_pkg::OP_READ, ones_key, 16'd1, 6'd0, 16'd256);
    send(fda_pkg::OP_WRITE, ones_key, 16'd256, 6'd0, 16'd0);
    send(fda_pkg::OP_WRITE, ones_key, 16'd65535, 6'd0, 16'd65535);
    send(fda_pkg::OP_READ, ones_key, 16'd10, 6'd63, 16'd0);
    send(fda_pkg::OP_WRITE, ones_key, 16'd10, 6'd16, 16'd0);
    send(fda_pkg::OP_QUERY, ones_key, 16'd0, 6'd15, 16'd0);
    send(fda_pkg::OP_QUERY, ones_key, 16'd0, 6'd1, 16'd0);
    send(fda_pkg::OP_DELETE, ones_key, 16'd0, 6'd0, 16'd0);
    send(fda_pkg::OP_QUERY, ones_key, 16'd0, 6'd1, 16'd0);
    send(fda_pkg::OP_DELETE, ones_key, 16'd0, 6'd0, 16'd0);
    send(OP_UNUSED_6, zero_key, 16'd0, 6'd0, 16'd0);
    send(OP_UNUSED_7, ones_key, 16'hffff, 6'h3f, 16'hffff);
    // Fill the directory to hit the full-directory status.
    for (int i = 2; i < 2 + NUM_SLOTS; i++)
      send(fda_pkg::OP_ALLOC, key_pool[i], 16'd1, 6'd0, 16'd0);

    for (int n = 0; n < 800; n++) begin
      no_idle = (n >= 300 && n < 450);
      random_item();
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("%0d transactions sent, %0d results checked", sent, sb.checked);
    $display("statuses ok/arg/notfound/exists/dirfull/datafull/range: %0d %0d %0d %0d %0d %0d %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4], sb.status_seen[5], sb.status_seen[6]);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("tb_top NOT OK");
    $finish;
  end
endmodule
